@@ rtl/ttt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and codes for the timer task table
// Slot record, request opcodes, status codes, the controller states and cell controls.
// ----------------------------------------------------------------------------
package ttt_pkg;

  localparam int unsigned TimeW = 63;
  localparam int unsigned IdW   = 8;
  localparam int unsigned RepW  = 32;

  // request opcodes
  localparam logic [2:0] FUNC_ADD_PER  = 3'd0;
  localparam logic [2:0] FUNC_ADD_ONE  = 3'd1;
  localparam logic [2:0] FUNC_REMOVE   = 3'd2;
  localparam logic [2:0] FUNC_TICK     = 3'd3;
  localparam logic [2:0] FUNC_TRIGGER  = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // one timer slot
  typedef struct packed {
    logic             periodic;
    logic [IdW-1:0]   ident;
    logic [TimeW-1:0] tim;
    logic [TimeW-1:0] prev;
    logic [RepW-1:0]  remaining;
    logic             mem_flag;
  } slot_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic shift;  // pop head, close ring at the tail
    logic keep;   // written-back head stays in the table
    logic add;    // load new slot at position count
  } cell_ctrl_t;

endpackage

@@ rtl/ttt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttt_cell: one slot of the timer table
// Holds one slot, takes its right neighbor on a shift, the written-back head
// when it is the tail of the occupied ring, or a new slot on an append.
// ----------------------------------------------------------------------------
module ttt_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                clk_i,
  input  ttt_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       count_i,
  input  ttt_pkg::slot_t      right_i,
  input  ttt_pkg::slot_t      wb_i,
  input  ttt_pkg::slot_t      new_i,
  output ttt_pkg::slot_t      slot_o
);

  localparam logic [CW-1:0] MyIdx  = CW'(IDX);
  localparam logic [CW-1:0] MyNext = CW'(IDX + 1);

  ttt_pkg::slot_t slot_q;

  // payload only: occupancy is tracked by the count in the controller
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      if (MyNext < count_i) begin
        slot_q <= right_i;
      end else if (MyNext == count_i && ctrl_i.keep) begin
        slot_q <= wb_i;
      end
    end else if (ctrl_i.add && MyIdx == count_i) begin
      slot_q <= new_i;
    end
  end

  assign slot_o = slot_q;

endmodule

@@ rtl/timer_task_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_task_table_unit: ordered timer slot table
// Add/remove requests and tick/trigger scans over a ring of slot cells.
// ----------------------------------------------------------------------------
// Add: accepted in idle, then the finish state registers the result; no new request
// is taken until the controller is back in idle. Remove, tick, trigger: the scan
// steps once per occupied slot, examining the head cell of the ring, then passes
// through the finish state; a stalled result output holds the scan.
// Reset empties the table at once; no clearing pass.
module timer_task_table_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  task_id_i,
  input  logic [62:0] time_value_i,
  input  logic [31:0] repeat_count_i,
  input  logic        mem_task_i,
  input  logic [62:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fired_o,
  output logic [7:0]  fired_id_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] Full = CW'(SLOTS);

  ttt_pkg::state_e     state_q, state_d;
  logic [CW-1:0]       count_q, steps_q;
  logic [2:0]          func_q;
  logic [7:0]          id_q;
  logic [62:0]         now_q;
  logic                found_q;
  logic [1:0]          stat_q;
  logic                pend_v_q;
  logic [7:0]          pend_id_q;
  logic                out_v_q, out_fired_q, out_last_q;
  logic [7:0]          out_id_q;
  logic [1:0]          out_stat_q;

  ttt_pkg::slot_t      cells [SLOTS];
  ttt_pkg::slot_t      head, wb, new_slot;
  ttt_pkg::cell_ctrl_t ctrl;
  logic                accept, adv, is_add, fire, drop, due;
  logic [63:0]         due_sum;

  assign accept = in_valid_i && in_ready_o;
  assign adv    = !out_v_q || out_ready_i;
  assign is_add = (func_i == ttt_pkg::FUNC_ADD_PER) || (func_i == ttt_pkg::FUNC_ADD_ONE);
  assign head   = cells[0];

  // new slot built straight from the request
  always_comb begin
    new_slot.periodic  = (func_i == ttt_pkg::FUNC_ADD_PER);
    new_slot.ident     = task_id_i;
    new_slot.tim       = time_value_i;
    new_slot.prev      = '0;
    new_slot.remaining = new_slot.periodic ? repeat_count_i : '0;
    new_slot.mem_flag  = new_slot.periodic ? mem_task_i : 1'b0;
  end

  // head evaluation: fire decision and write-back value
  assign due_sum = {1'b0, head.prev} + {1'b0, head.tim};
  assign due = head.periodic ? (due_sum <= {1'b0, now_q}) : (head.tim <= now_q);

  always_comb begin
    wb   = head;
    fire = 1'b0;
    drop = 1'b0;
    case (func_q)
      ttt_pkg::FUNC_TICK: begin
        if (due) begin
          fire = 1'b1;
          if (!head.periodic) begin
            drop = 1'b1;
          end else if (head.remaining != '0) begin
            wb.remaining = head.remaining - 32'd1;
            drop         = (head.remaining == 32'd1);
            wb.prev      = now_q;
          end else begin
            wb.prev = now_q;
          end
        end
      end
      ttt_pkg::FUNC_TRIGGER: fire = head.mem_flag;
      ttt_pkg::FUNC_REMOVE:  drop = !found_q && (head.ident == id_q);
      default: ;
    endcase
  end

  always_comb begin
    ctrl.shift = (state_q == ttt_pkg::ST_SCAN) && adv;
    ctrl.keep  = !drop;
    ctrl.add   = accept && is_add && (count_q != Full);
  end

  // ring of slot cells
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ttt_pkg::slot_t right;
    if (k == SLOTS - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cells[k+1];
    end
    ttt_cell #(.IDX(k), .CW(CW)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .right_i (right),
      .wb_i    (wb),
      .new_i   (new_slot),
      .slot_o  (cells[k])
    );
  end

  // controller next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttt_pkg::ST_IDLE: begin
        if (accept) begin
          if ((func_i == ttt_pkg::FUNC_REMOVE || func_i == ttt_pkg::FUNC_TICK ||
               func_i == ttt_pkg::FUNC_TRIGGER) && count_q != '0) begin
            state_d = ttt_pkg::ST_SCAN;
          end else begin
            state_d = ttt_pkg::ST_FINISH;
          end
        end
      end
      ttt_pkg::ST_SCAN: begin
        if (adv && steps_q == CW'(1)) state_d = ttt_pkg::ST_FINISH;
      end
      ttt_pkg::ST_FINISH: begin
        if (adv) state_d = ttt_pkg::ST_IDLE;
      end
      default: state_d = ttt_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ttt_pkg::ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttt_pkg::ST_IDLE;
      count_q  <= '0;
      steps_q  <= '0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ready_i) out_v_q <= 1'b0;
      if (accept) begin
        steps_q  <= count_q;
        found_q  <= 1'b0;
        pend_v_q <= 1'b0;
        if (ctrl.add) count_q <= count_q + CW'(1);
      end
      if (ctrl.shift) begin
        steps_q <= steps_q - CW'(1);
        if (drop) count_q <= count_q - CW'(1);
        if (func_q == ttt_pkg::FUNC_REMOVE && drop) found_q <= 1'b1;
        if (fire) begin
          pend_v_q <= 1'b1;
          if (pend_v_q) out_v_q <= 1'b1;
        end
      end
      if (state_q == ttt_pkg::ST_FINISH && adv) out_v_q <= 1'b1;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      id_q   <= task_id_i;
      now_q  <= now_time_i;
      stat_q <= (is_add && count_q == Full) ? ttt_pkg::STAT_FULL : ttt_pkg::STAT_OK;
    end
    if (ctrl.shift && fire) begin
      pend_id_q <= head.ident;
      if (pend_v_q) begin
        out_fired_q <= 1'b1;
        out_id_q    <= pend_id_q;
        out_last_q  <= 1'b0;
        out_stat_q  <= ttt_pkg::STAT_OK;
      end
    end
    if (state_q == ttt_pkg::ST_FINISH && adv) begin
      out_fired_q <= pend_v_q;
      out_id_q    <= pend_v_q ? pend_id_q : 8'd0;
      out_last_q  <= 1'b1;
      if (func_q == ttt_pkg::FUNC_REMOVE && !found_q) begin
        out_stat_q <= ttt_pkg::STAT_NOT_FOUND;
      end else begin
        out_stat_q <= stat_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign fired_o     = out_fired_q;
  assign fired_id_o  = out_id_q;
  assign last_o      = out_last_q;
  assign status_o    = out_stat_q;

endmodule
